FILE: src/scg_pkg.sv
// shared types and constants for the size-class table generator
// no dependencies; imported by every module under src
`timescale 1ns / 1ps

package scg_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_LOG_POINTER_BYTES = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_QUANTUM       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_TINY_MIN      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_MAX_LOOKUP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_PAGE          = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_GROUP         = 3'd5;

  localparam logic [2:0] GROUP_LOG_MAX = 3'd4;

  // width of the full size word and of the slab page shifter
  localparam int SIZE_W      = 64;
  localparam int PAGE_LOG_MX = 31;
  localparam int SCAN_W      = PAGE_LOG_MX + 32'(GROUP_LOG_MAX);

  typedef struct packed {
    logic [1:0] log_pointer_bytes;
    logic [3:0] log_quantum;
    logic [3:0] log_tiny_min;
    logic [4:0] log_max_lookup;
    logic [4:0] log_page;
    logic [2:0] log_group;
  } cfg_t;

  // one class encoding, handed from the front to the back
  typedef struct packed {
    logic [7:0] class_index;
    logic [5:0] base_log;
    logic [5:0] delta_log;
    logic [4:0] delta_count;
    logic       is_last;
  } desc_t;

  typedef struct packed {
    desc_t       desc;
    logic [62:0] class_size;
    logic        page_multiple;
    logic        is_bin;
    logic [5:0]  slab_pages;
    logic [5:0]  lookup_delta_log;
  } res_t;

endpackage

FILE: src/scg_front.sv
// class sequencer: takes step requests and walks the size-class encodings
// depends on scg_pkg; feeds scg_queue
`timescale 1ns / 1ps

module scg_front #(
  parameter int INDEX_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  scg_pkg::cfg_t cfg,
  input  logic          cfg_write,
  input  logic          push,
  input  logic          restart,
  input  logic          q_full,
  output logic          q_push,
  output scg_pkg::desc_t q_data
);
  import scg_pkg::*;

  typedef enum logic [3:0] {
    PH_TINY   = 4'b0001,
    PH_PSEUDO = 4'b0010,
    PH_FIRST  = 4'b0100,
    PH_GEO    = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [5:0] base;
    logic [5:0] delta;
    logic [4:0] count;
    logic       done;
  } adv_t;

  phase_t                  phase;
  logic [INDEX_BITS-1:0]   next_index;
  logic [5:0]              cur_base_log;
  logic [5:0]              cur_delta_log;
  logic [4:0]              cur_count;
  logic                    done;
  logic                    started;

  logic                    accept;
  logic                    start;
  phase_t                  e_phase;
  logic [INDEX_BITS-1:0]   e_index;
  logic [5:0]              e_base;
  logic [5:0]              e_delta;
  logic [4:0]              e_count;
  logic                    e_done;
  adv_t                    adv;
  logic [6:0]              ptr_width;
  logic [4:0]              ngroup;
  logic [4:0]              geo_lim;
  logic [6:0]              b7;
  logic [6:0]              d7;
  logic [5:0]              n6;

  // enter the geometric groups; the top group is empty when it has one class
  function automatic adv_t geo_start(input logic [6:0] b, input logic [6:0] d,
                                     input logic [6:0] ptr, input logic ng_one);
    adv_t r;
    r.phase = PH_GEO;
    r.base  = b[5:0];
    r.delta = d[5:0];
    r.count = 5'd1;
    r.done  = !((b < ptr - 7'd1) && !((b == ptr - 7'd2) && ng_one));
    return r;
  endfunction

  assign accept    = push && !q_full;
  assign start     = restart || !started;
  assign ptr_width = 7'd8 << cfg.log_pointer_bytes;
  assign ngroup    = 5'd1 << cfg.log_group;

  always_comb begin
    if (start) begin
      e_phase = (cfg.log_tiny_min < cfg.log_quantum) ? PH_TINY : PH_FIRST;
      e_index = '0;
      e_base  = {2'b00, cfg.log_tiny_min};
      e_delta = {2'b00, cfg.log_tiny_min};
      e_count = 5'd0;
      e_done  = 1'b0;
    end else begin
      e_phase = phase;
      e_index = next_index;
      e_base  = cur_base_log;
      e_delta = cur_delta_log;
      e_count = cur_count;
      e_done  = done;
    end
  end

  always_comb begin
    b7      = {1'b0, e_base};
    d7      = {1'b0, e_delta};
    n6      = {1'b0, e_count} + 6'd1;
    geo_lim = (b7 == ptr_width - 7'd2) ? ngroup - 5'd1 : ngroup;
    adv     = '{phase: e_phase, base: e_base, delta: e_delta, count: e_count, done: 1'b0};
    unique case (e_phase)
      PH_TINY: begin
        if (b7 + 7'd1 < {3'b000, cfg.log_quantum}) begin
          adv.base  = e_base + 6'd1;
          adv.delta = e_base;
          adv.count = 5'd0;
        end else begin
          adv.phase = PH_PSEUDO;
          adv.delta = e_base;
          adv.count = 5'd1;
        end
      end
      PH_PSEUDO: begin
        if (cfg.log_group != 3'd0) begin
          adv.phase = PH_FIRST;
          adv.base  = e_base + 6'd1;
          adv.delta = e_delta + 6'd1;
          adv.count = 5'd1;
        end else begin
          adv = geo_start(b7 + 7'd1 + {4'b0000, cfg.log_group}, d7 + 7'd1,
                          ptr_width, 1'b1);
        end
      end
      PH_FIRST: begin
        if (n6 < {1'b0, ngroup}) begin
          adv.count = n6[4:0];
        end else begin
          adv = geo_start(b7 + {4'b0000, cfg.log_group}, d7, ptr_width,
                          ngroup == 5'd1);
        end
      end
      PH_GEO: begin
        if (n6 <= {1'b0, geo_lim}) begin
          adv.count = n6[4:0];
        end else begin
          adv = geo_start(b7 + 7'd1, d7 + 7'd1, ptr_width, ngroup == 5'd1);
        end
      end
      default: begin
        adv.done = 1'b1;
      end
    endcase
  end

  assign q_push = accept && !e_done;

  always_comb begin
    q_data.class_index = 8'(e_index);
    q_data.base_log    = e_base;
    q_data.delta_log   = e_delta;
    q_data.delta_count = e_count;
    q_data.is_last     = adv.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TINY;
      next_index    <= '0;
      cur_base_log  <= '0;
      cur_delta_log <= '0;
      cur_count     <= '0;
      done          <= 1'b1;
      started       <= 1'b0;
    end else if (cfg_write) begin
      // any register write ends the table in progress
      done    <= 1'b1;
      started <= 1'b0;
    end else if (accept) begin
      started <= 1'b1;
      if (!e_done) begin
        next_index    <= e_index + 1'b1;
        phase         <= adv.phase;
        cur_base_log  <= adv.base;
        cur_delta_log <= adv.delta;
        cur_count     <= adv.count;
        done          <= adv.done;
      end
    end
  end

endmodule

FILE: src/scg_queue.sv
// two-entry queue of class encodings between the sequencer and the evaluator
// depends on scg_pkg
`timescale 1ns / 1ps

module scg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scg_pkg::desc_t wr_data,
  output logic           full,
  input  logic           pop,
  output scg_pkg::desc_t rd_data,
  output logic           empty
);
  import scg_pkg::*;

  desc_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full    = cnt == 2'd2;
  assign empty   = cnt == 2'd0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

FILE: src/scg_back.sv
// class evaluator: size, page and bin flags, slab page shift, result register
// depends on scg_pkg; reads from scg_queue
`timescale 1ns / 1ps

module scg_back (
  input  logic           clk,
  input  logic           rst,
  input  scg_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  scg_pkg::desc_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           out_valid,
  output scg_pkg::res_t  res
);
  import scg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t            st;
  desc_t             desc_r;
  logic [SIZE_W-1:0] size_r;
  logic              pm_r;
  logic              bin_r;
  logic [5:0]        lookup_r;
  logic [SCAN_W-1:0] scan_val;
  logic [4:0]        scan_sh;

  logic [SIZE_W-1:0] page_mask;
  logic [SIZE_W-1:0] bin_lim;
  logic [SIZE_W-1:0] lookup_lim;
  logic              is_bin;
  logic              res_load;

  assign q_pop      = (st == S_IDLE) && !q_empty;
  assign page_mask  = (SIZE_W'(1) << cfg.log_page) - SIZE_W'(1);
  assign bin_lim    = SIZE_W'(1) << ({1'b0, cfg.log_page} + {3'b000, cfg.log_group});
  assign lookup_lim = SIZE_W'(1) << cfg.log_max_lookup;
  assign is_bin     = size_r < bin_lim;
  // result register takes a new beat when it is free or being read
  assign res_load   = (st == S_OUT) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (!q_empty) begin
            desc_r <= q_data;
            size_r <= (SIZE_W'(1) << q_data.base_log)
                    + (SIZE_W'(q_data.delta_count) << q_data.delta_log);
            st     <= S_EVAL;
          end
        end
        S_EVAL: begin
          pm_r     <= (size_r & page_mask) == '0;
          bin_r    <= is_bin;
          lookup_r <= (size_r <= lookup_lim) ? desc_r.delta_log : 6'd0;
          scan_val <= size_r[SCAN_W-1:0];
          scan_sh  <= 5'd0;
          st       <= is_bin ? S_SCAN : S_OUT;
        end
        S_SCAN: begin
          // drop low zero bits, at most one page worth
          if (scan_val[0] || (scan_sh == cfg.log_page)) begin
            st <= S_OUT;
          end else begin
            scan_val <= scan_val >> 1;
            scan_sh  <= scan_sh + 5'd1;
          end
        end
        S_OUT: begin
          if (res_load) begin
            res.desc             <= desc_r;
            res.class_size       <= size_r[62:0];
            res.page_multiple    <= pm_r;
            res.is_bin           <= bin_r;
            res.slab_pages       <= bin_r ? scan_val[5:0] : 6'd0;
            res.lookup_delta_log <= lookup_r;
            st                   <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  a_scan_bins_only: assert property (@(posedge clk) disable iff (rst)
    st == S_SCAN |-> bin_r)
    else $error("slab page shift running on a non-bin class");
  a_eval_after_pop: assert property (@(posedge clk) disable iff (rst)
    st == S_EVAL |-> $past(q_pop))
    else $error("evaluation without a queue beat");
  a_nonbin_pages: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.is_bin |-> res.slab_pages == 6'd0)
    else $error("slab pages set on a non-bin class");

endmodule

FILE: src/size_class_table_generator.sv
// channel   | handshake             | payload
// request   | push / full           | restart
// result    | empty / pop           | class_index .. is_last
// config    | cfg_write             | cfg_index, cfg_data
//
// each step request that yields a class passes the evaluator states idle,
// eval and out; slab bins also pass the scan state, where the one-bit-per-cycle
// slab page shifter drops s = min(trailing zeros of the size, log_page) low bits.
// the sequencer takes a request per cycle while its two-entry queue has room.
// synchronous reset; no clearing pass. a full result register holds the
// evaluator, and a full queue raises full.
// depends on scg_pkg, scg_front, scg_queue, scg_back
`timescale 1ns / 1ps

module size_class_table_generator #(
  parameter int INDEX_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             restart,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       class_index,
  output logic [5:0]                       base_log,
  output logic [5:0]                       delta_log,
  output logic [4:0]                       delta_count,
  output logic [62:0]                      class_size,
  output logic                             page_multiple,
  output logic                             is_bin,
  output logic [5:0]                       slab_pages,
  output logic [5:0]                       lookup_delta_log,
  output logic                             is_last,
  input  logic                             cfg_write,
  input  logic [scg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [scg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scg_pkg::*;

  cfg_t  cfg;
  logic  cfg_hit;
  logic  q_push;
  desc_t q_wr_data;
  logic  q_full;
  logic  q_pop;
  desc_t q_rd_data;
  logic  q_empty;
  logic  out_valid;
  res_t  res;

  // writes past the register list leave the sequencer alone
  assign cfg_hit = cfg_write && (cfg_index <= REG_LOG_GROUP);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log_pointer_bytes <= 2'd3;
      cfg.log_quantum       <= 4'd4;
      cfg.log_tiny_min      <= 4'd3;
      cfg.log_max_lookup    <= 5'd12;
      cfg.log_page          <= 5'd12;
      cfg.log_group         <= 3'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOG_POINTER_BYTES: cfg.log_pointer_bytes <= cfg_data[1:0];
        REG_LOG_QUANTUM:       cfg.log_quantum       <= cfg_data[3:0];
        REG_LOG_TINY_MIN:      cfg.log_tiny_min      <= cfg_data[3:0];
        REG_LOG_MAX_LOOKUP:    cfg.log_max_lookup    <= cfg_data[4:0];
        REG_LOG_PAGE:          cfg.log_page          <= cfg_data[4:0];
        REG_LOG_GROUP: begin
          // clamp to the largest supported group
          cfg.log_group <= (cfg_data[2:0] > GROUP_LOG_MAX) ? GROUP_LOG_MAX : cfg_data[2:0];
        end
        default: begin
        end
      endcase
    end
  end

  scg_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_write(cfg_hit),
    .push     (push),
    .restart  (restart),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  scg_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_data(q_wr_data),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  scg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .out_valid(out_valid),
    .res      (res)
  );

  assign full             = q_full;
  assign empty            = !out_valid;
  assign class_index      = res.desc.class_index;
  assign base_log         = res.desc.base_log;
  assign delta_log        = res.desc.delta_log;
  assign delta_count      = res.desc.delta_count;
  assign is_last          = res.desc.is_last;
  assign class_size       = res.class_size;
  assign page_multiple    = res.page_multiple;
  assign is_bin           = res.is_bin;
  assign slab_pages       = res.slab_pages;
  assign lookup_delta_log = res.lookup_delta_log;

endmodule
